// ----- rtl/svc_pkg.sv -----
// ----------------------------------------------------------------------------
// svc_pkg: shared types and constants of the signed varint codec
// Transfer payload structs, controller commands and datapath status.
// ----------------------------------------------------------------------------
package svc_pkg;

    localparam int unsigned MaxCodeBytes = 10;
    localparam int unsigned CountW       = 4;
    localparam int unsigned PosW         = 7;

    localparam logic ReqEncode  = 1'b0;
    localparam logic ReqDecode  = 1'b1;
    localparam logic KindByte   = 1'b0;
    localparam logic KindValue  = 1'b1;

    localparam logic [5:0]      FirstMask  = 6'h3f;
    localparam logic [6:0]      NextMask   = 7'h7f;
    localparam logic [63:0]     FirstLimit = 64'h40;
    localparam logic [63:0]     NextLimit  = 64'h80;
    localparam logic [PosW-1:0] FirstBits  = PosW'(6);
    localparam logic [PosW-1:0] NextBits   = PosW'(7);

    typedef struct packed {
        logic               req_type;
        logic signed [63:0] enc_value;
        logic [7:0]         in_byte;
    } t_in;

    typedef struct packed {
        logic               out_kind;
        logic [7:0]         out_byte;
        logic               out_last;
        logic signed [63:0] decoded_value;
        logic               decode_error;
    } t_out;

    typedef struct packed {
        logic enc_load;
        logic enc_step;
        logic dec_byte;
    } t_cmd;

    typedef struct packed {
        logic enc_first_more;
        logic enc_step_more;
        logic dec_result;
    } t_stat;

endpackage

// ----- rtl/svc_dp.sv -----
// ----------------------------------------------------------------------------
// svc_dp: datapath of the signed varint codec
// Holds the encode shift register, the decode accumulator and the output
// payload register.
// ----------------------------------------------------------------------------
module svc_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  svc_pkg::t_in  i_in_data,
    input  svc_pkg::t_cmd i_cmd,
    output svc_pkg::t_stat o_stat,
    output svc_pkg::t_out o_out_data
);

    logic [63:0]                    r_mag;
    logic [63:0]                    r_acc;
    logic [svc_pkg::PosW-1:0]       r_pos;
    logic                           r_sign;
    logic [svc_pkg::CountW-1:0]     r_count;
    svc_pkg::t_out                  r_out;

    logic                           w_neg;
    logic [63:0]                    w_abs;
    logic                           w_first_more;
    logic                           w_step_more;
    logic [63:0]                    w_shifted;
    logic [63:0]                    w_acc;
    logic                           w_sign;
    logic [svc_pkg::CountW-1:0]     w_count;
    logic                           w_overlong;
    logic                           w_done;
    logic [63:0]                    w_value;

    always_comb begin
        w_neg        = i_in_data.enc_value[63];
        w_abs        = w_neg ? (64'd0 - 64'(i_in_data.enc_value))
                             : 64'(i_in_data.enc_value);
        w_first_more = (w_abs >= svc_pkg::FirstLimit);
        w_step_more  = (r_mag >= svc_pkg::NextLimit);

        w_shifted = r_pos[svc_pkg::PosW-1] ? 64'd0
                  : (64'(i_in_data.in_byte[6:0]) << r_pos[5:0]);
        if (r_count == '0) begin
            w_acc  = 64'(i_in_data.in_byte[5:0] & svc_pkg::FirstMask);
            w_sign = i_in_data.in_byte[6];
        end else begin
            w_acc  = r_acc | w_shifted;
            w_sign = r_sign;
        end
        w_count    = r_count + svc_pkg::CountW'(1);
        w_overlong = i_in_data.in_byte[7]
                   && (w_count >= svc_pkg::CountW'(svc_pkg::MaxCodeBytes));
        w_done     = !i_in_data.in_byte[7] || w_overlong;
        w_value    = w_sign ? (64'd0 - w_acc) : w_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_pos   <= '0;
            r_sign  <= 1'b0;
            r_count <= '0;
        end else if (i_cmd.dec_byte) begin
            if (w_done) begin
                r_acc   <= '0;
                r_pos   <= '0;
                r_sign  <= 1'b0;
                r_count <= '0;
            end else begin
                r_acc   <= w_acc;
                r_pos   <= (r_count == '0) ? svc_pkg::FirstBits
                                           : r_pos + svc_pkg::NextBits;
                r_sign  <= w_sign;
                r_count <= w_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.enc_load) begin
            r_mag                 <= w_abs >> 6;
            r_out.out_kind        <= svc_pkg::KindByte;
            r_out.out_byte        <= {w_first_more, w_neg, w_abs[5:0]};
            r_out.out_last        <= !w_first_more;
            r_out.decoded_value   <= '0;
            r_out.decode_error    <= 1'b0;
        end else if (i_cmd.enc_step) begin
            r_mag                 <= r_mag >> 7;
            r_out.out_kind        <= svc_pkg::KindByte;
            r_out.out_byte        <= {w_step_more, r_mag[6:0] & svc_pkg::NextMask};
            r_out.out_last        <= !w_step_more;
            r_out.decoded_value   <= '0;
            r_out.decode_error    <= 1'b0;
        end else if (i_cmd.dec_byte) begin
            r_out.out_kind        <= svc_pkg::KindValue;
            r_out.out_byte        <= '0;
            r_out.out_last        <= 1'b0;
            r_out.decoded_value   <= w_overlong ? 64'd0 : w_value;
            r_out.decode_error    <= w_overlong;
        end
    end

    assign o_stat.enc_first_more = w_first_more;
    assign o_stat.enc_step_more  = w_step_more;
    assign o_stat.dec_result     = w_done;
    assign o_out_data            = r_out;

endmodule

// ----- rtl/svc_ctrl.sv -----
// ----------------------------------------------------------------------------
// svc_ctrl: controller of the signed varint codec
// Runs the transfer handshakes and steps the datapath through encode runs and decode bytes.
// ----------------------------------------------------------------------------
module svc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic           i_req_type,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  svc_pkg::t_stat i_stat,
    output svc_pkg::t_cmd  o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_ENC
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;
    logic   w_in_fire;

    always_comb begin
        w_out_free = !r_out_valid || !i_out_stall;
        o_in_stall = (r_state != ST_IDLE) || !w_out_free;
        w_in_fire  = i_in_valid && !o_in_stall;

        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = w_out_free ? 1'b0 : r_out_valid;

        case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    if (i_req_type == svc_pkg::ReqEncode) begin
                        o_cmd.enc_load = 1'b1;
                        n_out_valid    = 1'b1;
                        if (i_stat.enc_first_more) begin
                            n_state = ST_ENC;
                        end
                    end else begin
                        o_cmd.dec_byte = 1'b1;
                        n_out_valid    = i_stat.dec_result;
                    end
                end
            end
            ST_ENC: begin
                if (w_out_free) begin
                    o_cmd.enc_step = 1'b1;
                    n_out_valid    = 1'b1;
                    if (!i_stat.enc_step_more) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_enc_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ENC) |-> o_in_stall)
        else $error("Input transfer possible during an encode run.");

    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.enc_load, o_cmd.enc_step, o_cmd.dec_byte}))
        else $error("More than one datapath command at once.");

    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !(o_cmd.enc_load || o_cmd.enc_step
                                            || o_cmd.dec_byte))
        else $error("Datapath command would overwrite a waiting result.");

    a_step_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.enc_load || o_cmd.enc_step) |=> r_out_valid)
        else $error("Encoded byte lost.");

endmodule

// ----- rtl/signed_varint_codec.sv -----
// ----------------------------------------------------------------------------
// signed_varint_codec: sign-magnitude varint encoder and decoder
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// An encode request emits 1 to 10 bytes from the shift register that walks
// the magnitude seven bits at a time, one per cycle while the output is not
// stalled; the next input is taken once the final byte leaves the output
// register. Decode bytes go in at one per cycle while no result waits
// stalled. A single output register parts the two sides, so an input
// transfer is accepted in the same cycle that a waiting result is taken.
// ----------------------------------------------------------------------------
module signed_varint_codec (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  svc_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output svc_pkg::t_out o_out_data
);

    svc_pkg::t_cmd  w_cmd;
    svc_pkg::t_stat w_stat;

    svc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_in_data.req_type),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    svc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out_data (o_out_data)
    );

endmodule

// ----- tb/sv/tb_signed_varint_codec.sv -----
// ----------------------------------------------------------------------------
// tb_signed_varint_codec: self-checking testbench of the signed varint codec
// Encode and decode requests go in through a sender that works in bursts with
// random gaps, while the result side stalls on a pattern that changes over the
// run. A scoreboard class keeps its own copy of the decoder state, predicts
// every result when an input transfer is accepted, and checks each result
// transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_signed_varint_codec;

    class varint_scoreboard;
        svc_pkg::t_out pending[$];
        logic [7:0]    code_bytes[$];
        logic [63:0]   accum_mag;
        logic [6:0]    bit_pos;
        logic          sign_bit;
        logic [3:0]    byte_count;
        int            errors;

        function new();
            clear_decoder();
            errors = 0;
        endfunction

        function void clear_decoder();
            accum_mag  = '0;
            bit_pos    = '0;
            sign_bit   = 1'b0;
            byte_count = '0;
        endfunction

        function void build_code(logic [63:0] value);
            logic [63:0] mag;
            code_bytes.delete();
            mag = value[63] ? -value : value;
            code_bytes.push_back({mag >= svc_pkg::FirstLimit, value[63], mag[5:0]});
            mag = mag >> 6;
            while (mag != 0) begin
                code_bytes.push_back({mag >= svc_pkg::NextLimit, mag[6:0]});
                mag = mag >> 7;
            end
        endfunction

        function void take_byte(logic [7:0] b);
            svc_pkg::t_out r;
            logic [63:0]   slice;
            if (byte_count == 0) begin
                sign_bit  = b[6];
                accum_mag = {58'd0, b[5:0]};
                bit_pos   = svc_pkg::FirstBits;
            end else begin
                slice = {57'd0, b[6:0]};
                if (bit_pos < 64) begin
                    accum_mag = accum_mag | (slice << bit_pos);
                end
                bit_pos = bit_pos + svc_pkg::NextBits;
            end
            byte_count = byte_count + 4'd1;
            r = '0;
            r.out_kind = svc_pkg::KindValue;
            if (!b[7]) begin
                r.decoded_value = sign_bit ? -accum_mag : accum_mag;
                clear_decoder();
                pending.push_back(r);
            end else if (byte_count >= svc_pkg::MaxCodeBytes) begin
                r.decode_error = 1'b1;
                clear_decoder();
                pending.push_back(r);
            end
        endfunction

        function void note_input(svc_pkg::t_in item);
            svc_pkg::t_out r;
            if (item.req_type == svc_pkg::ReqEncode) begin
                build_code(item.enc_value);
                foreach (code_bytes[i]) begin
                    r = '0;
                    r.out_kind = svc_pkg::KindByte;
                    r.out_byte = code_bytes[i];
                    r.out_last = !code_bytes[i][7];
                    pending.push_back(r);
                end
            end else begin
                take_byte(item.in_byte);
            end
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(svc_pkg::t_out got);
            svc_pkg::t_out want;
            if (pending.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, %s",
                         $time, "actual below");
                $display("%0t: actual kind %0b byte %02h last %0b value %0h error %0b",
                         $time, got.out_kind, got.out_byte, got.out_last,
                         got.decoded_value, got.decode_error);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("out_kind", 64'(want.out_kind), 64'(got.out_kind));
            compare_field("out_byte", 64'(want.out_byte), 64'(got.out_byte));
            compare_field("out_last", 64'(want.out_last), 64'(got.out_last));
            compare_field("decoded_value", want.decoded_value, got.decoded_value);
            compare_field("decode_error", 64'(want.decode_error),
                          64'(got.decode_error));
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_stall;
    svc_pkg::t_in  i_in_data;
    logic          o_out_valid;
    logic          i_out_stall;
    svc_pkg::t_out o_out_data;

    varint_scoreboard sb = new();
    int burst_left = 0;
    int items_sent = 0;

    signed_varint_codec u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                sb.note_input(i_in_data);
            end
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(o_out_data);
            end
        end
    end

    initial begin
        int stall_mode;
        int stall_left;
        i_out_stall = 1'b0;
        stall_mode  = 0;
        stall_left  = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                stall_left = $urandom_range(16, 128);
            end
            stall_left--;
            case (stall_mode)
                0: begin
                    i_out_stall <= 1'b0;
                end
                1: begin
                    i_out_stall <= 1'($urandom_range(0, 1));
                end
                default: begin
                    i_out_stall <= ($urandom_range(0, 3) != 0);
                end
            endcase
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        v = rand64();
        case ($urandom_range(0, 5))
            0: begin
                v = 64'd1 << $urandom_range(0, 63);
            end
            1: begin
                v = (64'd1 << $urandom_range(0, 63)) - 64'd1;
            end
            default: begin
                v = v >> $urandom_range(0, 63);
            end
        endcase
        if ($urandom_range(0, 1) == 1) begin
            v = -v;
        end
        return v;
    endfunction

    task automatic send_item(input svc_pkg::t_in item);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                i_in_data  <= svc_pkg::t_in'({$urandom, $urandom, $urandom});
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_encode(input logic [63:0] value);
        svc_pkg::t_in item;
        item.req_type  = svc_pkg::ReqEncode;
        item.enc_value = value;
        item.in_byte   = 8'($urandom);
        send_item(item);
    endtask

    task automatic send_decode(input logic [7:0] code_byte);
        svc_pkg::t_in item;
        item.req_type  = svc_pkg::ReqDecode;
        item.enc_value = rand64();
        item.in_byte   = code_byte;
        send_item(item);
    endtask

    // An encode request may land inside a code, since it must leave the
    // decoder state untouched.
    task automatic send_code(input logic [63:0] value);
        logic [7:0] code[$];
        sb.build_code(value);
        code = sb.code_bytes;
        foreach (code[i]) begin
            if (i > 0 && $urandom_range(0, 9) == 0) begin
                send_encode(rand_value());
            end
            send_decode(code[i]);
        end
    endtask

    task automatic send_loose_code(input int len, input bit overlong);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            b    = 8'($urandom);
            b[7] = overlong || (i < len - 1);
            send_decode(b);
        end
    endtask

    initial begin
        int pick;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_encode(64'd0);
        send_encode(64'd63);
        send_encode(64'd64);
        send_encode(-64'sd1);
        send_encode(-64'sd64);
        send_encode(-64'sd65);
        send_encode(64'h7fff_ffff_ffff_ffff);
        send_encode(64'h8000_0000_0000_0000);
        send_encode(64'h8000_0000_0000_0001);
        send_code(-64'sd64);
        send_decode(8'h40);
        send_decode(8'h3f);
        send_loose_code(10, 1'b1);

        while (items_sent < 340) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                send_encode(rand_value());
            end else if (pick < 65) begin
                send_code(rand_value());
            end else if (pick < 80) begin
                send_loose_code($urandom_range(1, 10), 1'b0);
            end else if (pick < 90) begin
                send_loose_code(10, 1'b1);
            end else begin
                repeat ($urandom_range(1, 4)) send_decode(8'($urandom));
            end
        end
        i_in_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb_signed_varint_codec: done, clean");
        end else begin
            $display("tb_signed_varint_codec: done, errors");
        end
        $finish;
    end

    initial begin
        #(8 * 400000);
        $display("tb_signed_varint_codec: done, errors");
        $finish;
    end

endmodule
